FILE: hw/rtl/nca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nca_pkg
// Shared constants, types and codes for the note channel allocator.
// ----------------------------------------------------------------------------
package nca_pkg;

  // Channel table geometry (CHANNELS may range from 2 to 8)
  localparam int unsigned CHANNELS = 8;
  localparam int unsigned CH_W     = $clog2(CHANNELS);
  localparam int unsigned NOTE_W   = 7;
  localparam int unsigned AGE_W    = 32;
  localparam int unsigned CHAN_W   = 3;
  localparam int unsigned ENT_W    = NOTE_W + AGE_W;

  // Request codes
  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_WRITE = 3'b100
  } state_e;

  // Outcome of one pass over the channel table
  typedef struct packed {
    logic            hit;
    logic [CH_W-1:0] hit_idx;
    logic            free;
    logic [CH_W-1:0] free_idx;
    logic [CH_W-1:0] min_idx;
  } scan_res_t;

endpackage

FILE: hw/rtl/nca_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nca_if
// Request and response channel interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
interface nca_req_if;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [nca_pkg::NOTE_W-1:0] note;

  modport source (output valid, output req_type, output note, input ready);
  modport sink   (input valid, input req_type, input note, output ready);
endinterface

interface nca_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [nca_pkg::CHAN_W-1:0] channel;
  logic                      found;
  logic                      stolen;

  modport source (output valid, output channel, output found, output stolen, input ready);
  modport sink   (input valid, input channel, input found, input stolen, output ready);
endinterface

FILE: hw/rtl/nca_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nca_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nca_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/nca_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nca_scan
// Tracks note match, first free channel and oldest stamp over a table pass.
// ----------------------------------------------------------------------------
module nca_scan (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          ent_vld_i,
  input  logic [nca_pkg::CH_W-1:0]      ent_idx_i,
  input  logic [nca_pkg::NOTE_W-1:0]    ent_note_i,
  input  logic [nca_pkg::AGE_W-1:0]     ent_age_i,
  input  logic [nca_pkg::NOTE_W-1:0]    req_note_i,
  output nca_pkg::scan_res_t            res_o
);

  logic                         hit_q, hit_d;
  logic [nca_pkg::CH_W-1:0]     hit_idx_q, hit_idx_d;
  logic                         free_q, free_d;
  logic [nca_pkg::CH_W-1:0]     free_idx_q, free_idx_d;
  logic [nca_pkg::CH_W-1:0]     min_idx_q, min_idx_d;
  logic [nca_pkg::AGE_W-1:0]    min_age_q, min_age_d;

  // Fold one entry into the running results
  always_comb begin
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    min_idx_d  = min_idx_q;
    min_age_d  = min_age_q;
    if (start_i) begin
      hit_d  = 1'b0;
      free_d = 1'b0;
    end else if (ent_vld_i) begin
      if (!hit_q && (ent_note_i == req_note_i)) begin
        hit_d     = 1'b1;
        hit_idx_d = ent_idx_i;
      end
      if (!free_q && (ent_note_i == '0)) begin
        free_d     = 1'b1;
        free_idx_d = ent_idx_i;
      end
      // Stamps order as signed values; ties keep the lower index
      if ((ent_idx_i == '0) || ($signed(ent_age_i) < $signed(min_age_q))) begin
        min_idx_d = ent_idx_i;
        min_age_d = ent_age_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else begin
      hit_q  <= hit_d;
      free_q <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    min_idx_q  <= min_idx_d;
    min_age_q  <= min_age_d;
  end

  assign res_o.hit      = hit_q;
  assign res_o.hit_idx  = hit_idx_q;
  assign res_o.free     = free_q;
  assign res_o.free_idx = free_idx_q;
  assign res_o.min_idx  = min_idx_q;

endmodule

FILE: hw/rtl/note_channel_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// note_channel_allocator_top
// Least-recently-used voice channel allocator over a RAM-held channel table.
// ----------------------------------------------------------------------------
// Sequence: after a request word is accepted, the table is walked with one RAM
// read per channel, then the channel is decided and written back and the
// response word is presented; the write-back waits while the response is unread.
// Requests: a new request is accepted only in idle, after the previous one is
// written back, as the single RAM read port walking the table sets the pace.
// Reset: all channels free with zero stamps, age counter zero; table entries
// read as zero until first written, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module note_channel_allocator_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  nca_req_if.sink    req_i,
  nca_rsp_if.source  rsp_o
);

  localparam logic [nca_pkg::CH_W-1:0] LastIdx = nca_pkg::CH_W'(nca_pkg::CHANNELS - 1);

  nca_pkg::state_e              state_q, state_d;
  logic                         req_type_q;
  logic [nca_pkg::NOTE_W-1:0]   note_q;
  logic [nca_pkg::AGE_W-1:0]    counter_q;
  logic [nca_pkg::CHANNELS-1:0] valid_q;

  logic [nca_pkg::CH_W-1:0]     rd_idx_q;
  logic                         rd_busy_q;
  logic                         ent_vld_q;
  logic [nca_pkg::CH_W-1:0]     ent_idx_q;
  logic                         ent_live_q;

  logic                         out_vld_q;
  logic [nca_pkg::CHAN_W-1:0]   out_chan_q;
  logic                         out_found_q;
  logic                         out_stolen_q;

  logic                         req_acc;
  logic                         out_free;
  logic                         commit;
  logic                         we;
  logic [nca_pkg::CH_W-1:0]     pick;
  logic [nca_pkg::ENT_W-1:0]    wdata;
  logic                         found;
  logic                         stolen;
  logic [nca_pkg::ENT_W-1:0]    rdata;
  logic [nca_pkg::NOTE_W-1:0]   ent_note;
  logic [nca_pkg::AGE_W-1:0]    ent_age;
  nca_pkg::scan_res_t           scan_res;

  assign req_acc  = req_i.valid && req_i.ready;
  assign out_free = !out_vld_q || rsp_o.ready;
  assign commit   = (state_q == nca_pkg::ST_WRITE) && out_free;

  // Channel table: note and stamp per entry
  nca_ram #(
    .WIDTH (nca_pkg::ENT_W),
    .DEPTH (nca_pkg::CHANNELS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (pick),
    .wdata_i (wdata),
    .raddr_i (rd_idx_q),
    .rdata_o (rdata)
  );

  // Entries never written read as free with a zero stamp
  assign ent_note = ent_live_q ? rdata[nca_pkg::ENT_W-1:nca_pkg::AGE_W] : '0;
  assign ent_age  = ent_live_q ? rdata[nca_pkg::AGE_W-1:0] : '0;

  nca_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (req_acc),
    .ent_vld_i  (ent_vld_q),
    .ent_idx_i  (ent_idx_q),
    .ent_note_i (ent_note),
    .ent_age_i  (ent_age),
    .req_note_i (note_q),
    .res_o      (scan_res)
  );

  // Decide the channel and the write-back word
  always_comb begin
    pick   = scan_res.hit_idx;
    found  = scan_res.hit;
    stolen = 1'b0;
    wdata  = {note_q, {nca_pkg::AGE_W{1'b0}}};
    we     = 1'b0;
    if (req_type_q == nca_pkg::REQ_RELEASE) begin
      we = commit && scan_res.hit;
    end else begin
      found = 1'b1;
      wdata = {note_q, counter_q};
      we    = commit;
      if (!scan_res.hit) begin
        if (scan_res.free) begin
          pick = scan_res.free_idx;
        end else begin
          pick   = scan_res.min_idx;
          stolen = 1'b1;
        end
      end
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      nca_pkg::ST_IDLE: begin
        if (req_acc) state_d = nca_pkg::ST_SCAN;
      end
      nca_pkg::ST_SCAN: begin
        if (ent_vld_q && (ent_idx_q == LastIdx)) state_d = nca_pkg::ST_WRITE;
      end
      nca_pkg::ST_WRITE: begin
        if (out_free) state_d = nca_pkg::ST_IDLE;
      end
      default: state_d = nca_pkg::ST_IDLE;
    endcase
  end

  assign req_i.ready = (state_q == nca_pkg::ST_IDLE);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= nca_pkg::ST_IDLE;
      counter_q <= '0;
      valid_q   <= '0;
      rd_idx_q  <= '0;
      rd_busy_q <= 1'b0;
      ent_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // Walk the read address over the table
      if (req_acc) begin
        rd_idx_q  <= '0;
        rd_busy_q <= 1'b1;
      end else if (rd_busy_q) begin
        if (rd_idx_q == LastIdx) begin
          rd_busy_q <= 1'b0;
        end else begin
          rd_idx_q <= rd_idx_q + nca_pkg::CH_W'(1);
        end
      end
      ent_vld_q <= rd_busy_q;
      // Mark written entries and advance the stamp on allocation
      if (we) begin
        valid_q[pick] <= 1'b1;
      end
      if (commit && (req_type_q == nca_pkg::REQ_ALLOC)) begin
        counter_q <= counter_q + nca_pkg::AGE_W'(1);
      end
      // Output word register
      if (commit) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      req_type_q <= req_i.req_type;
      note_q     <= req_i.note;
    end
    ent_idx_q  <= rd_idx_q;
    ent_live_q <= valid_q[rd_idx_q];
    if (commit) begin
      out_chan_q   <= found ? nca_pkg::CHAN_W'(pick) : '0;
      out_found_q  <= found;
      out_stolen_q <= stolen;
    end
  end

  assign rsp_o.valid   = out_vld_q;
  assign rsp_o.channel = out_chan_q;
  assign rsp_o.found   = out_found_q;
  assign rsp_o.stolen  = out_stolen_q;

endmodule
